// ===== rtl/aais_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aais_pkg
// Types, constants and helpers shared by the area-average image scaler.
// ----------------------------------------------------------------------------
package aais_pkg;

    localparam int MAX_WIDTH    = 4096;
    localparam int MAX_HEIGHT   = 4096;
    localparam int MAX_CHANNELS = 4;
    localparam int MAX_UPSCALE  = 8;

    localparam int DIM_W     = 13;
    localparam int COORD_W   = 12;
    localparam int CH_W      = 3;
    localparam int CFG_IDX_W = 3;
    localparam int PIX_W     = 8;
    localparam int POS_W     = 2 * COORD_W + 1;
    localparam int AREA_W    = 2 * COORD_W + 1;
    localparam int ACC_W     = AREA_W + PIX_W - 1;
    localparam int SCALE_W   = DIM_W + $clog2(MAX_UPSCALE);
    localparam int OPEN_ROWS = MAX_UPSCALE + 1;
    localparam int K_W       = $clog2(OPEN_ROWS);
    localparam int BIT_W     = $clog2(PIX_W);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_WIDTH  = 3'd0,
        CFG_SRC_HEIGHT = 3'd1,
        CFG_DST_WIDTH  = 3'd2,
        CFG_DST_HEIGHT = 3'd3,
        CFG_CHANNELS   = 3'd4
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GEOM,
        S_MUL1,
        S_MUL2,
        S_SUM,
        S_DIV,
        S_EMIT,
        S_NEXT
    } t_state;

    typedef struct packed {
        logic [PIX_W-1:0] in_c0;
        logic [PIX_W-1:0] in_c1;
        logic [PIX_W-1:0] in_c2;
        logic [PIX_W-1:0] in_c3;
    } t_in_item;

    typedef struct packed {
        logic [PIX_W-1:0]   out_c0;
        logic [PIX_W-1:0]   out_c1;
        logic [PIX_W-1:0]   out_c2;
        logic [PIX_W-1:0]   out_c3;
        logic [COORD_W-1:0] dest_x;
        logic [COORD_W-1:0] dest_y;
        logic               run_end;
        logic               frame_end;
    } t_out_item;

    typedef struct packed {
        logic                    load;
        logic                    rd_en;
        logic                    mul_en;
        logic                    sum_en;
        logic                    div_en;
        logic                    col_carried;
        logic                    col_done;
        logic                    row_carried;
        logic                    row_done;
        logic [K_W-1:0]          k;
        logic [COORD_W-1:0]      x;
        logic [AREA_W-1:0]       area;
        logic [AREA_W-1:0]       divisor;
        logic [MAX_CHANNELS-1:0] chan_en;
    } t_lane_ctrl;

    typedef struct packed {
        logic               load;
        logic [COORD_W-1:0] dest_x;
        logic [COORD_W-1:0] dest_y;
        logic               run_end;
        logic               frame_end;
    } t_emit;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [CH_W-1:0] clamp_chan(input logic [CH_W-1:0] v);
        logic [CH_W-1:0] r;
        if (v == '0) begin
            r = CH_W'(1);
        end else if (v > CH_W'(MAX_CHANNELS)) begin
            r = CH_W'(MAX_CHANNELS);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ===== rtl/area_average_image_scaler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// area_average_image_scaler
// Area-averaging resampler for raster pixel streams of up to four channels.
// ----------------------------------------------------------------------------
// Each source pixel is walked over every destination pixel it overlaps, row
// by row. One overlap step runs through geometry, two multiplies, accumulate
// and advance; a step that completes a destination pixel adds a restoring
// divide per channel lane (all lanes in parallel) and the load of the output
// register, which waits while that register holds an untaken result. Column
// carries live in per-lane registers, row carries in a per-lane memory of one
// word per destination column; both are always written before they are read
// within a frame, so no clearing pass runs after reset. A configuration write
// to a defined register restarts the frame.
// ----------------------------------------------------------------------------
module area_average_image_scaler (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [aais_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [aais_pkg::DIM_W-1:0]         i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  aais_pkg::t_in_item                 i_in_item,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output aais_pkg::t_out_item                o_out_item
);
    import aais_pkg::*;

    t_lane_ctrl                         w_lane;
    t_emit                              w_emit;
    logic                               w_free;
    logic [MAX_CHANNELS-1:0][PIX_W-1:0] w_px;
    logic [MAX_CHANNELS-1:0][PIX_W-1:0] w_avg;

    assign w_px[0] = i_in_item.in_c0;
    assign w_px[1] = i_in_item.in_c1;
    assign w_px[2] = i_in_item.in_c2;
    assign w_px[3] = i_in_item.in_c3;

    aais_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_out_free  (w_free),
        .o_lane      (w_lane),
        .o_emit      (w_emit)
    );

    for (genvar c = 0; c < MAX_CHANNELS; c++) begin : g_lane
        aais_lane u_lane (
            .i_clk  (i_clk),
            .i_ctrl (w_lane),
            .i_en   (w_lane.chan_en[c]),
            .i_px   (w_px[c]),
            .o_avg  (w_avg[c])
        );
    end

    aais_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_emit  (w_emit),
        .i_avg   (w_avg),
        .i_ready (i_out_ready),
        .o_valid (o_out_valid),
        .o_item  (o_out_item),
        .o_free  (w_free)
    );

endmodule

// ===== rtl/aais_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aais_lane
// One channel: weight multiply, row/column accumulators, restoring divider.
// ----------------------------------------------------------------------------
module aais_lane (
    input  logic                               i_clk,
    input  aais_pkg::t_lane_ctrl               i_ctrl,
    input  logic                               i_en,
    input  logic [aais_pkg::PIX_W-1:0]         i_px,
    output logic [aais_pkg::PIX_W-1:0]         o_avg
);
    import aais_pkg::*;

    logic [PIX_W-1:0] r_px;
    logic [ACC_W-1:0] r_prod;
    logic [ACC_W-1:0] r_ra_q;
    logic [ACC_W-1:0] r_rem;
    logic [ACC_W-1:0] r_dsh;
    logic [PIX_W-1:0] r_q;
    logic             r_sat;
    logic [ACC_W-1:0] r_oca [OPEN_ROWS];
    logic [ACC_W-1:0] r_row_mem [MAX_WIDTH];

    logic [ACC_W-1:0] w_col_in;
    logic [ACC_W-1:0] w_row_in;
    logic [ACC_W-1:0] w_v;

    always_comb begin
        w_col_in = i_ctrl.col_carried ? r_oca[i_ctrl.k] : '0;
        w_row_in = (i_ctrl.col_done && i_ctrl.row_carried) ? r_ra_q : '0;
        w_v      = ACC_W'(r_prod + w_col_in + w_row_in);
    end

    // row accumulator memory
    always_ff @(posedge i_clk) begin
        if (i_ctrl.sum_en && i_ctrl.col_done && !i_ctrl.row_done) begin
            r_row_mem[i_ctrl.x] <= w_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.rd_en) begin
            r_ra_q <= r_row_mem[i_ctrl.x];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_px <= i_en ? i_px : '0;
        end
        if (i_ctrl.mul_en) begin
            r_prod <= ACC_W'(i_ctrl.area) * ACC_W'(r_px);
        end
        if (i_ctrl.sum_en) begin
            if (!i_ctrl.col_done) begin
                r_oca[i_ctrl.k] <= w_v;
            end
            r_rem <= w_v;
            r_dsh <= ACC_W'({i_ctrl.divisor, {(PIX_W-1){1'b0}}});
            r_sat <= ({1'b0, w_v} >= {i_ctrl.divisor, {PIX_W{1'b0}}});
            r_q   <= '0;
        end else if (i_ctrl.div_en) begin
            if (r_rem >= r_dsh) begin
                r_rem <= r_rem - r_dsh;
                r_q   <= {r_q[PIX_W-2:0], 1'b1};
            end else begin
                r_q   <= {r_q[PIX_W-2:0], 1'b0};
            end
            r_dsh <= r_dsh >> 1;
        end
    end

    assign o_avg = r_sat ? {PIX_W{1'b1}} : r_q;

endmodule

// ===== rtl/aais_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aais_ctrl
// Configuration registers and the overlap walk over destination pixels.
// ----------------------------------------------------------------------------
module aais_ctrl (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [aais_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [aais_pkg::DIM_W-1:0]          i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_out_free,
    output aais_pkg::t_lane_ctrl                o_lane,
    output aais_pkg::t_emit                     o_emit
);
    import aais_pkg::*;

    t_state r_state, n_state;

    logic [DIM_W-1:0]   r_src_w, r_src_h, r_dst_w, r_dst_h;
    logic [CH_W-1:0]    r_chan;
    logic [AREA_W-1:0]  r_wh;
    logic [COORD_W-1:0] r_col_pos, r_row_pos;
    logic [POS_W-1:0]   r_x0, r_x1, r_xs, r_y0, r_y1, r_ys;
    logic [COORD_W-1:0] r_xf, r_yf;
    logic [COORD_W-1:0] r_cx, r_cy;
    logic [POS_W-1:0]   r_clo, r_clo_y, r_hi_x, r_hi_y;
    logic [K_W-1:0]     r_k;
    logic [DIM_W-1:0]   r_ox, r_oy;
    logic               r_cc, r_cd, r_rc, r_rdn, r_last_c, r_last_r;
    logic [AREA_W-1:0]  r_area;
    logic [BIT_W-1:0]   r_bit;

    logic [SCALE_W-1:0] w_w_up, w_h_up;
    logic [DIM_W-1:0]   w_w, w_h;
    logic [POS_W-1:0]   w_sw, w_sh;
    logic [POS_W-1:0]   w_hx, w_hy, w_lx, w_ly, w_tx, w_ty;
    logic               w_accept, w_cfg_acc, w_cfg_hit, w_more_x, w_more_y;
    logic               w_col_last, w_row_last;

    always_comb begin
        w_w_up = {r_src_w, {(SCALE_W-DIM_W){1'b0}}};
        w_h_up = {r_src_h, {(SCALE_W-DIM_W){1'b0}}};
        w_w    = (SCALE_W'(r_dst_w) > w_w_up) ? DIM_W'(w_w_up) : r_dst_w;
        w_h    = (SCALE_W'(r_dst_h) > w_h_up) ? DIM_W'(w_h_up) : r_dst_h;
        w_sw   = POS_W'(r_src_w);
        w_sh   = POS_W'(r_src_h);
        w_hx   = r_clo + w_sw;
        w_hy   = r_clo_y + w_sh;
        w_lx   = (r_clo > r_x0) ? r_clo : r_x0;
        w_ly   = (r_clo_y > r_y0) ? r_clo_y : r_y0;
        w_tx   = (w_hx < r_x1) ? w_hx : r_x1;
        w_ty   = (w_hy < r_y1) ? w_hy : r_y1;
        w_more_x   = r_hi_x < r_x1;
        w_more_y   = r_hi_y < r_y1;
        w_col_last = ({1'b0, r_col_pos} == r_src_w - DIM_W'(1));
        w_row_last = ({1'b0, r_row_pos} == r_src_h - DIM_W'(1));
        w_accept   = i_in_valid && o_in_ready;
        w_cfg_acc  = i_cfg_valid && o_cfg_ready;
        case (i_cfg_index)
            CFG_SRC_WIDTH, CFG_SRC_HEIGHT, CFG_DST_WIDTH,
            CFG_DST_HEIGHT, CFG_CHANNELS: w_cfg_hit = 1'b1;
            default:                      w_cfg_hit = 1'b0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (w_accept) n_state = S_GEOM;
            S_GEOM: n_state = S_MUL1;
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = S_SUM;
            S_SUM:  n_state = (r_cd && r_rdn) ? S_DIV : S_NEXT;
            S_DIV:  if (r_bit == '0) n_state = S_EMIT;
            S_EMIT: if (i_out_free) n_state = S_NEXT;
            S_NEXT: n_state = (w_more_x || w_more_y) ? S_GEOM : S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cfg_ready = (r_state == S_IDLE);
        o_in_ready  = (r_state == S_IDLE) && !i_cfg_valid;
        o_lane.load        = w_accept;
        o_lane.rd_en       = (r_state == S_GEOM);
        o_lane.mul_en      = (r_state == S_MUL2);
        o_lane.sum_en      = (r_state == S_SUM);
        o_lane.div_en      = (r_state == S_DIV);
        o_lane.col_carried = r_cc;
        o_lane.col_done    = r_cd;
        o_lane.row_carried = r_rc;
        o_lane.row_done    = r_rdn;
        o_lane.k           = r_k;
        o_lane.x           = r_cx;
        o_lane.area        = r_area;
        o_lane.divisor     = r_wh;
        for (int c = 0; c < MAX_CHANNELS; c++) begin
            o_lane.chan_en[c] = (CH_W'(c) < r_chan);
        end
        o_emit.load      = (r_state == S_EMIT) && i_out_free;
        o_emit.dest_x    = r_cx;
        o_emit.dest_y    = r_cy;
        o_emit.run_end   = r_last_c && r_last_r;
        o_emit.frame_end = ({1'b0, r_cx} == w_w - DIM_W'(1))
                        && ({1'b0, r_cy} == w_h - DIM_W'(1));
    end

    always_ff @(posedge i_clk) begin
        r_wh <= AREA_W'(r_src_w) * AREA_W'(r_src_h);
        if (r_state == S_GEOM) begin
            r_ox     <= DIM_W'(w_tx - w_lx);
            r_oy     <= DIM_W'(w_ty - w_ly);
            r_cc     <= r_clo < r_x0;
            r_cd     <= w_hx <= r_x1;
            r_rc     <= r_clo_y < r_y0;
            r_rdn    <= w_hy <= r_y1;
            r_last_c <= (w_hx <= r_x1) && ((w_hx + w_sw) > r_x1);
            r_last_r <= (w_hy <= r_y1) && ((w_hy + w_sh) > r_y1);
            r_hi_x   <= w_hx;
            r_hi_y   <= w_hy;
        end
        if (r_state == S_MUL1) begin
            r_area <= AREA_W'(r_ox) * AREA_W'(r_oy);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_src_w   <= DIM_W'(1);
            r_src_h   <= DIM_W'(1);
            r_dst_w   <= DIM_W'(1);
            r_dst_h   <= DIM_W'(1);
            r_chan    <= CH_W'(1);
            r_col_pos <= '0;
            r_row_pos <= '0;
            r_x0      <= '0;
            r_xf      <= '0;
            r_xs      <= '0;
            r_y0      <= '0;
            r_yf      <= '0;
            r_ys      <= '0;
            r_x1      <= '0;
            r_y1      <= '0;
            r_cx      <= '0;
            r_cy      <= '0;
            r_clo     <= '0;
            r_clo_y   <= '0;
            r_k       <= '0;
            r_bit     <= '0;
        end else begin
            r_state <= n_state;
            if (w_cfg_acc) begin
                case (i_cfg_index)
                    CFG_SRC_WIDTH:  r_src_w <= clamp_dim(i_cfg_data, DIM_W'(MAX_WIDTH));
                    CFG_SRC_HEIGHT: r_src_h <= clamp_dim(i_cfg_data, DIM_W'(MAX_HEIGHT));
                    CFG_DST_WIDTH:  r_dst_w <= clamp_dim(i_cfg_data, DIM_W'(MAX_WIDTH));
                    CFG_DST_HEIGHT: r_dst_h <= clamp_dim(i_cfg_data, DIM_W'(MAX_HEIGHT));
                    CFG_CHANNELS:   r_chan  <= clamp_chan(i_cfg_data[CH_W-1:0]);
                    default: ;
                endcase
                if (w_cfg_hit) begin
                    r_col_pos <= '0;
                    r_row_pos <= '0;
                    r_x0      <= '0;
                    r_xf      <= '0;
                    r_xs      <= '0;
                    r_y0      <= '0;
                    r_yf      <= '0;
                    r_ys      <= '0;
                end
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_cx    <= r_xf;
                        r_clo   <= r_xs;
                        r_cy    <= r_yf;
                        r_clo_y <= r_ys;
                        r_k     <= '0;
                        r_x1    <= r_x0 + POS_W'(w_w);
                        r_y1    <= r_y0 + POS_W'(w_h);
                    end
                end
                S_SUM: begin
                    r_bit <= BIT_W'(PIX_W - 1);
                end
                S_DIV: begin
                    r_bit <= r_bit - BIT_W'(1);
                end
                S_NEXT: begin
                    if (w_more_x) begin
                        r_cx  <= r_cx + COORD_W'(1);
                        r_clo <= r_hi_x;
                    end else if (w_more_y) begin
                        r_cy    <= r_cy + COORD_W'(1);
                        r_clo_y <= r_hi_y;
                        r_k     <= r_k + K_W'(1);
                        r_cx    <= r_xf;
                        r_clo   <= r_xs;
                    end else if (w_col_last) begin
                        r_col_pos <= '0;
                        r_x0      <= '0;
                        r_xf      <= '0;
                        r_xs      <= '0;
                        if (w_row_last) begin
                            r_row_pos <= '0;
                            r_y0      <= '0;
                            r_yf      <= '0;
                            r_ys      <= '0;
                        end else begin
                            r_row_pos <= r_row_pos + COORD_W'(1);
                            r_y0      <= r_y1;
                            if (r_hi_y == r_y1) begin
                                r_yf <= r_cy + COORD_W'(1);
                                r_ys <= r_hi_y;
                            end else begin
                                r_yf <= r_cy;
                                r_ys <= r_clo_y;
                            end
                        end
                    end else begin
                        r_col_pos <= r_col_pos + COORD_W'(1);
                        r_x0      <= r_x1;
                        if (r_hi_x == r_x1) begin
                            r_xf <= r_cx + COORD_W'(1);
                            r_xs <= r_hi_x;
                        end else begin
                            r_xf <= r_cx;
                            r_xs <= r_clo;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

// ===== rtl/aais_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aais_merge
// Joins the lane averages with coordinates into the output register.
// ----------------------------------------------------------------------------
module aais_merge (
    input  logic                                                i_clk,
    input  logic                                                i_rst_n,
    input  aais_pkg::t_emit                                     i_emit,
    input  logic [aais_pkg::MAX_CHANNELS-1:0][aais_pkg::PIX_W-1:0] i_avg,
    input  logic                                                i_ready,
    output logic                                                o_valid,
    output aais_pkg::t_out_item                                 o_item,
    output logic                                                o_free
);
    import aais_pkg::*;

    logic      r_valid;
    t_out_item r_item;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_emit.load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_emit.load) begin
            r_item.out_c0    <= i_avg[0];
            r_item.out_c1    <= i_avg[1];
            r_item.out_c2    <= i_avg[2];
            r_item.out_c3    <= i_avg[3];
            r_item.dest_x    <= i_emit.dest_x;
            r_item.dest_y    <= i_emit.dest_y;
            r_item.run_end   <= i_emit.run_end;
            r_item.frame_end <= i_emit.frame_end;
        end
    end

endmodule

// ===== rtl/aais_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aais_checker
// Port-level checks on the scaler, attached by bind.
// ----------------------------------------------------------------------------
module aais_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    input  logic                               o_cfg_ready,
    input  logic                               i_in_valid,
    input  logic                               o_in_ready,
    input  logic                               o_out_valid,
    input  logic                               i_out_ready,
    input  aais_pkg::t_out_item                o_out_item
);

    // last destination pixel of a frame closes the run of its source pixel
    a_frame_end_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.frame_end) |-> o_out_item.run_end)
        else $error("frame_end without run_end");

    // a source pixel transfer always starts a multi-cycle walk
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready right after a transfer");

    // a new result only appears mid-walk, never while taking input
    a_out_mid_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !o_in_ready)
        else $error("result appeared while idle");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_item)))
        else $error("stalled result changed");

    // register write and pixel transfer never share an edge
    a_cfg_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready) |-> !(i_in_valid && o_in_ready))
        else $error("register write together with pixel transfer");

endmodule

bind area_average_image_scaler aais_checker u_aais_checker (.*);
